FILE: hdl/sbd_pkg.sv
// Shared types, codes and helpers for the signer bitmap decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package sbd_pkg;

  // Field widths fixed by the result format
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 16;  // header rank count
  localparam int unsigned CMP_W   = CNT_W + 1;
  localparam int unsigned FIRST_W = 11;  // first_rank port
  localparam int unsigned RCNT_W  = 12;  // rank_count port
  localparam int unsigned TRITS   = 5;   // ternary digits per byte

  // Result queue depth
  localparam int unsigned QDEPTH  = 8;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Header position codes
  localparam logic [1:0] HDR_VER    = 2'd0;
  localparam logic [1:0] HDR_CNT_LO = 2'd1;
  localparam logic [1:0] HDR_CNT_HI = 2'd2;
  localparam logic [1:0] HDR_DONE   = 2'd3;

  // Version byte codes
  localparam logic [7:0] VER_BASE2 = 8'd0;
  localparam logic [7:0] VER_BASE3 = 8'd1;

  // Result kinds
  localparam logic KIND_SLICE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Rank advance per payload byte
  localparam int unsigned STEP_BASE2 = 8;
  localparam int unsigned STEP_BASE3 = 5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNC     = 2'd1,
    ST_UNSUP     = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  typedef struct packed {
    logic               item_kind;
    logic [FIRST_W-1:0] first_rank;
    logic [7:0]         base_mask;
    logic [7:0]         fallback_mask;
    logic [RCNT_W-1:0]  rank_count;
    status_t            status;
    logic               final_result;
  } res_t;

  // What the decoder hands to the result queue each cycle
  typedef struct packed {
    logic [1:0] num;     // results written this cycle, 0..2
    res_t       first;
    res_t       second;
  } push_t;

  typedef struct packed {
    logic [TRITS-1:0] base;
    logic [TRITS-1:0] fallback;
  } tern_t;

  // Split a byte into five base-3 digits, low digit first.
  // Divide by 3 is done as (d * 171) >> 9, exact for d < 256.
  function automatic tern_t trit_split(input logic [7:0] b);
    logic [7:0]  d;
    logic [16:0] prod;
    logic [7:0]  q;
    logic [1:0]  r;
    tern_t       t;
    d = b;
    t = '0;
    for (int i = 0; i < TRITS; i++) begin
      prod = 17'(d) * 17'd171;
      q    = 8'(prod >> 9);
      r    = 2'(d - 8'(q * 8'd3));
      t.base[i]     = (r == 2'd1);
      t.fallback[i] = (r == 2'd2);
      d = q;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sbd_decode.sv
// Input register, header/rank state and per-byte decode for the bitmap decoder.
// Depends on sbd_pkg. Emits up to two results per byte toward the result queue.
`default_nettype none

module sbd_decode
  import sbd_pkg::*;
#(
  parameter int unsigned MAX_RANKS = 2048
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_take,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic             in_eos,
  input  wire logic             allow_two_sets,
  output logic                  stage_valid,
  output push_t                 push
);

  localparam int unsigned RANK_W = $clog2(MAX_RANKS + STEP_BASE2);

  // Input stage
  logic              sv_r;
  logic [BYTE_W-1:0] byte_r;
  logic              eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else begin
      sv_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_byte;
      eos_r  <= in_eos;
    end
  end

  assign stage_valid = sv_r;

  // Bitmap state
  logic [1:0]        pos_r, pos_step, pos_nxt;
  logic              tern_r, tern_step, tern_nxt;
  status_t           err_r, err_step, err_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_step, cnt_nxt;
  logic [RANK_W-1:0] nr_r, nr_step, nr_nxt;

  // Slice decode
  logic              slice_go;
  logic [CMP_W-1:0]  left;
  logic [7:0]        keep;
  tern_t             trits;
  logic [7:0]        bm, fm;
  res_t              slice_res, stat_res;
  status_t           st;
  logic [RCNT_W-1:0] rc;

  assign slice_go = sv_r && (pos_r == HDR_DONE) && (err_r == ST_OK) &&
                    (cnt_r <= CNT_W'(MAX_RANKS)) && (CMP_W'(nr_r) < CMP_W'(cnt_r));

  assign left  = CMP_W'(cnt_r) - CMP_W'(nr_r);
  assign trits = trit_split(byte_r);

  // Lanes at or beyond the rank count are masked off
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      keep[i] = (left > CMP_W'(i));
    end
  end

  always_comb begin
    if (tern_r) begin
      bm = {3'b000, trits.base & keep[TRITS-1:0]};
      fm = {3'b000, trits.fallback & keep[TRITS-1:0]};
    end else begin
      bm = byte_r & keep;
      fm = 8'h00;
    end
  end

  // Header parsing and rank advance
  always_comb begin
    pos_step  = pos_r;
    tern_step = tern_r;
    err_step  = err_r;
    cnt_step  = cnt_r;
    nr_step   = nr_r;
    if (sv_r) begin
      unique case (pos_r)
        HDR_VER: begin
          pos_step = HDR_CNT_LO;
          if (byte_r == VER_BASE2) begin
            tern_step = 1'b0;
          end else if (allow_two_sets && byte_r == VER_BASE3) begin
            tern_step = 1'b1;
          end else begin
            tern_step = 1'b0;
            err_step  = allow_two_sets ? ST_MALFORMED : ST_UNSUP;
          end
        end
        HDR_CNT_LO: begin
          pos_step = HDR_CNT_HI;
          cnt_step = {8'h00, byte_r};
        end
        HDR_CNT_HI: begin
          pos_step = HDR_DONE;
          cnt_step = {byte_r, cnt_r[7:0]};
        end
        HDR_DONE: begin
          if (slice_go) begin
            nr_step = nr_r + (tern_r ? RANK_W'(STEP_BASE3) : RANK_W'(STEP_BASE2));
          end
        end
        default: begin
          pos_step = pos_r;
        end
      endcase
    end
  end

  // End of stream returns everything to reset
  always_comb begin
    if (sv_r && eos_r) begin
      pos_nxt  = HDR_VER;
      tern_nxt = 1'b0;
      err_nxt  = ST_OK;
      cnt_nxt  = '0;
      nr_nxt   = '0;
    end else begin
      pos_nxt  = pos_step;
      tern_nxt = tern_step;
      err_nxt  = err_step;
      cnt_nxt  = cnt_step;
      nr_nxt   = nr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= HDR_VER;
      tern_r <= 1'b0;
      err_r  <= ST_OK;
      cnt_r  <= '0;
      nr_r   <= '0;
    end else begin
      pos_r  <= pos_nxt;
      tern_r <= tern_nxt;
      err_r  <= err_nxt;
      cnt_r  <= cnt_nxt;
      nr_r   <= nr_nxt;
    end
  end

  // Final status, by precedence, from the state after this byte
  always_comb begin
    rc = '0;
    priority if (pos_step != HDR_DONE) begin
      st = ST_TRUNC;
    end else if (err_step != ST_OK) begin
      st = err_step;
    end else if (cnt_step > CNT_W'(MAX_RANKS)) begin
      st = ST_MALFORMED;
    end else begin
      rc = RCNT_W'(cnt_step);
      st = (CMP_W'(nr_step) < CMP_W'(cnt_step)) ? ST_TRUNC : ST_OK;
    end
  end

  always_comb begin
    slice_res               = '0;
    slice_res.item_kind     = KIND_SLICE;
    slice_res.first_rank    = FIRST_W'(nr_r);
    slice_res.base_mask     = bm;
    slice_res.fallback_mask = fm;
    slice_res.status        = ST_OK;

    stat_res                = '0;
    stat_res.item_kind      = KIND_STATUS;
    stat_res.rank_count     = rc;
    stat_res.status         = st;
    stat_res.final_result   = 1'b1;
  end

  // Slice goes first, status after it
  always_comb begin
    push.num    = 2'(slice_go) + 2'(sv_r && eos_r);
    push.first  = slice_go ? slice_res : stat_res;
    push.second = stat_res;
  end

  // Two results only when a slice is followed by the closing status
  a_two_means_slice_then_status: assert property (
    @(posedge clk) disable iff (!rst_n)
    (push.num == 2'd2) |-> (push.first.item_kind == KIND_SLICE && eos_r)
  ) else $error("two results without a slice followed by status");

  // A closing byte leaves the decoder ready for a new header
  a_eos_clears_state: assert property (
    @(posedge clk) disable iff (!rst_n)
    (sv_r && eos_r) |=> (pos_r == HDR_VER && nr_r == '0 && err_r == ST_OK)
  ) else $error("state not cleared after end of stream");

endmodule

`default_nettype wire

FILE: hdl/sbd_result_fifo.sv
// Result queue for the bitmap decoder: up to two writes, one read per cycle.
// Depends on sbd_pkg for the result type and depth.
`default_nettype none

module sbd_result_fifo
  import sbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire push_t       push,
  input  wire logic        pop,
  output logic             not_empty,
  output logic [QCNT_W-1:0] fill,
  output res_t             head
);

  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign not_empty = (cnt_r != '0);
  assign fill      = cnt_r;
  assign head      = mem[rd_r];

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_r + QPTR_W'(1)] <= push.second;
    end
  end

  // Pointers and fill count
  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(push.num);
    rd_nxt  = rd_r + QPTR_W'(do_pop);
    cnt_nxt = cnt_r + QCNT_W'(push.num) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Writer never overruns the queue
  a_no_overflow: assert property (
    @(posedge clk) disable iff (!rst_n)
    (QCNT_W'(push.num) <= QCNT_W'(QDEPTH) - cnt_r)
  ) else $error("result queue overflow");

  // Pointer distance agrees with the fill count
  a_ptrs_track_count: assert property (
    @(posedge clk) disable iff (!rst_n)
    (QPTR_W'(wr_r - rd_r) == QPTR_W'(cnt_r))
  ) else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: hdl/signer_bitmap_base2_base3_decoder.sv
// Signer bitmap decoder: accepts one bitmap byte per cycle while in_ready is
// high and streams back a mask slice per payload byte within the rank count
// plus a status at end of stream. The input byte is registered, decoded in the
// next cycle and written into an 8-entry result queue, from which its results
// are taken. Sustained rate is one byte per cycle while out_ready stays high
// and each byte gives at most one result; the closing byte may give two
// results, which the queue absorbs and drains one per cycle while out_ready is
// high. in_ready drops when the queue plus the byte in the decode stage could
// hold more than four results. Depends on sbd_pkg, sbd_decode, sbd_result_fifo.
`default_nettype none

module signer_bitmap_base2_base3_decoder
  import sbd_pkg::*;
#(
  parameter int unsigned MAX_RANKS = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Configuration
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  // Input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [BYTE_W-1:0]  in_data_byte,
  input  wire logic               in_end_of_stream,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_item_kind,
  output logic [FIRST_W-1:0]      out_first_rank,
  output logic [7:0]              out_base_mask,
  output logic [7:0]              out_fallback_mask,
  output logic [RCNT_W-1:0]       out_rank_count,
  output logic [1:0]              out_status,
  output logic                    out_final_result
);

  logic              allow_r;
  logic              stage_valid;
  logic              in_take;
  push_t             push;
  logic [QCNT_W-1:0] fill;
  logic [QCNT_W:0]   committed;
  res_t              head;

  // allow_two_sets register, reset to accepting Base3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_r <= 1'b1;
    end else if (cfg_wr_en) begin
      allow_r <= cfg_wr_data;
    end
  end

  // Room for two results from the staged byte and two from the new one
  assign committed = (QCNT_W + 1)'(fill) + (stage_valid ? (QCNT_W + 1)'(2) : '0);
  assign in_ready  = (committed <= (QCNT_W + 1)'(QDEPTH - 4));
  assign in_take   = in_valid && in_ready;

  sbd_decode #(
    .MAX_RANKS (MAX_RANKS)
  ) u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_take        (in_take),
    .in_byte        (in_data_byte),
    .in_eos         (in_end_of_stream),
    .allow_two_sets (allow_r),
    .stage_valid    (stage_valid),
    .push           (push)
  );

  sbd_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_ready),
    .not_empty (out_valid),
    .fill      (fill),
    .head      (head)
  );

  // Result fields from the queue head
  assign out_item_kind     = head.item_kind;
  assign out_first_rank    = head.first_rank;
  assign out_base_mask     = head.base_mask;
  assign out_fallback_mask = head.fallback_mask;
  assign out_rank_count    = head.rank_count;
  assign out_status        = head.status;
  assign out_final_result  = head.final_result;

endmodule

`default_nettype wire

FILE: bench/signer_bitmap_base2_base3_decoder_tb.sv
// Self-checking bench for signer_bitmap_base2_base3_decoder: directed and random
// bitmap byte streams, with predicted slices and status compared field by field.
// Depends on sbd_pkg and the decoder RTL.

module signer_bitmap_base2_base3_decoder_tb;
  import sbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RANKS = 2048;
  localparam int IDLE_PCT  = 24;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } bitmap_byte_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = '0;
  logic               in_end_of_stream = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_item_kind;
  logic [FIRST_W-1:0] out_first_rank;
  logic [7:0]         out_base_mask;
  logic [7:0]         out_fallback_mask;
  logic [RCNT_W-1:0]  out_rank_count;
  logic [1:0]         out_status;
  logic               out_final_result;

  // Stimulus and expectation stores
  bitmap_byte_t byte_queue[$];
  res_t         expected_results[$];
  bitmap_byte_t next_byte;
  res_t         got;
  res_t         want;
  int           bytes_queued = 0;
  int           mismatch_count = 0;
  logic         no_idle = 1'b0;

  // Decoder shadow state
  logic         allow_two_sets = 1'b1;
  logic [1:0]   hdr_pos = HDR_VER;
  logic         ternary = 1'b0;
  status_t      hdr_err = ST_OK;
  logic [15:0]  count_q = '0;
  int           payload_cnt = 0;
  int           rank_next = 0;

  signer_bitmap_base2_base3_decoder #(
    .MAX_RANKS(MAX_RANKS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item_kind    (out_item_kind),
    .out_first_rank   (out_first_rank),
    .out_base_mask    (out_base_mask),
    .out_fallback_mask(out_fallback_mask),
    .out_rank_count   (out_rank_count),
    .out_status       (out_status),
    .out_final_result (out_final_result)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Payload bytes a complete bitmap carries
  function automatic int needed_bytes(input logic tern, input int cnt);
    return tern ? (cnt + 4) / 5 : (cnt + 7) / 8;
  endfunction

  function automatic string describe(input res_t r);
    return $sformatf("kind=%0d first=%0d base=%02h fb=%02h cnt=%0d st=%0d fin=%0d",
                     r.item_kind, r.first_rank, r.base_mask, r.fallback_mask,
                     r.rank_count, r.status, r.final_result);
  endfunction

  // Predict the results of one transferred byte and advance the shadow state
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    int   left;
    int   d;
    int   dig;
    res_t r;
    case (hdr_pos)
      HDR_VER: begin
        if (b == VER_BASE2) begin
          ternary = 1'b0;
        end else if (allow_two_sets && b == VER_BASE3) begin
          ternary = 1'b1;
        end else begin
          ternary = 1'b0;
          hdr_err = allow_two_sets ? ST_MALFORMED : ST_UNSUP;
        end
        hdr_pos = HDR_CNT_LO;
      end
      HDR_CNT_LO: begin
        count_q = {8'h00, b};
        hdr_pos = HDR_CNT_HI;
      end
      HDR_CNT_HI: begin
        count_q[15:8] = b;
        hdr_pos = HDR_DONE;
      end
      default: begin
        if (hdr_err == ST_OK && count_q <= MAX_RANKS &&
            payload_cnt < needed_bytes(ternary, count_q)) begin
          r = '0;
          r.item_kind = KIND_SLICE;
          r.first_rank = FIRST_W'(rank_next);
          left = int'(count_q) - rank_next;
          if (ternary) begin
            d = b;
            for (int i = 0; i < TRITS; i++) begin
              dig = d % 3;
              d = d / 3;
              if (i < left) begin
                if (dig == 1) r.base_mask[i] = 1'b1;
                else if (dig == 2) r.fallback_mask[i] = 1'b1;
              end
            end
          end else begin
            r.base_mask = (left >= 8) ? b : (b & 8'((1 << left) - 1));
          end
          expected_results.push_back(r);
          payload_cnt++;
          rank_next += ternary ? STEP_BASE3 : STEP_BASE2;
        end
      end
    endcase

    // Closing status, then back to a fresh bitmap
    if (eos) begin
      r = '0;
      r.item_kind = KIND_STATUS;
      r.final_result = 1'b1;
      if (hdr_pos != HDR_DONE) begin
        r.status = ST_TRUNC;
      end else if (hdr_err != ST_OK) begin
        r.status = hdr_err;
      end else if (count_q > MAX_RANKS) begin
        r.status = ST_MALFORMED;
      end else begin
        r.rank_count = count_q[RCNT_W-1:0];
        r.status = (payload_cnt < needed_bytes(ternary, count_q)) ? ST_TRUNC : ST_OK;
      end
      expected_results.push_back(r);
      hdr_pos = HDR_VER;
      ternary = 1'b0;
      hdr_err = ST_OK;
      count_q = '0;
      payload_cnt = 0;
      rank_next = 0;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eos);
    bitmap_byte_t e;
    e.data = b;
    e.eos = eos;
    byte_queue.push_back(e);
    bytes_queued++;
  endtask

  // Header plus len payload bytes of random content; last byte ends the stream
  task automatic add_bitmap(input logic [7:0] ver, input logic [15:0] cnt, input int len);
    logic tern;
    int   n;
    tern = (ver == VER_BASE3) && allow_two_sets;
    n = (len < 0) ? 0 : len;
    push_byte(ver, 1'b0);
    push_byte(cnt[7:0], 1'b0);
    push_byte(cnt[15:8], n == 0);
    for (int i = 0; i < n; i++) begin
      if (!tern) push_byte(8'($urandom_range(0, 255)), i == n - 1);
      else if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(243, 255)), i == n - 1);
      else push_byte(8'($urandom_range(0, 242)), i == n - 1);
    end
  endtask

  // Raw random bytes, end of stream at random and always on the last one
  task automatic add_raw(input int len, input int eos_pct);
    for (int i = 0; i < len; i++)
      push_byte(8'($urandom_range(0, 255)),
                i == len - 1 || $urandom_range(0, 99) < eos_pct);
  endtask

  // Mostly well-formed bitmaps, the rest broken headers and noise
  task automatic add_traffic(input int budget);
    int         stop;
    int         sel;
    int         cnt;
    int         need;
    int         len;
    logic [7:0] ver;
    stop = bytes_queued + budget;
    while (bytes_queued < stop) begin
      sel = $urandom_range(0, 99);
      if (sel < 68) begin
        if (allow_two_sets) ver = $urandom_range(0, 1) ? VER_BASE3 : VER_BASE2;
        else ver = ($urandom_range(0, 4) == 0) ? VER_BASE3 : VER_BASE2;
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
        need = needed_bytes((ver == VER_BASE3) && allow_two_sets, cnt);
        case ($urandom_range(0, 9))
          6, 7:    len = need + int'($urandom_range(1, 3));
          8, 9:    len = need - int'($urandom_range(1, 3));
          default: len = need;
        endcase
        add_bitmap(ver, 16'(cnt), len);
      end else if (sel < 78) begin
        add_bitmap(8'($urandom_range(2, 255)), 16'($urandom()), $urandom_range(0, 3));
      end else if (sel < 86) begin
        ver = $urandom_range(0, 1) ? VER_BASE3 : VER_BASE2;
        add_bitmap(ver, 16'($urandom_range(MAX_RANKS + 1, 65535)), $urandom_range(0, 3));
      end else if (sel < 94) begin
        add_raw($urandom_range(1, 2), 0);
      end else begin
        add_raw($urandom_range(1, 6), 30);
      end
    end
  endtask

  // Wait for every byte and result to drain, then let the pipeline settle
  task automatic wait_idle(input int settle);
    while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_allow(input logic v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    allow_two_sets = v;
  endtask

  // Byte driver: predicts on each transfer, then offers the next byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_data_byte, in_end_of_stream);
      if (!in_valid || in_ready) begin
        if (byte_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_byte = byte_queue.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_byte.data;
          in_end_of_stream <= next_byte.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.item_kind = out_item_kind;
        got.first_rank = out_first_rank;
        got.base_mask = out_base_mask;
        got.fallback_mask = out_fallback_mask;
        got.rank_count = out_rank_count;
        got.status = status_t'(out_status);
        got.final_result = out_final_result;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result: %s", describe(got));
        end else begin
          want = expected_results.pop_front();
          if (got.item_kind !== want.item_kind || got.first_rank !== want.first_rank ||
              got.base_mask !== want.base_mask ||
              got.fallback_mask !== want.fallback_mask ||
              got.rank_count !== want.rank_count || got.status !== want.status ||
              got.final_result !== want.final_result) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %s, got %s", describe(want), describe(got));
          end
        end
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Run timeout
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Reset, phases and final verdict
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, two sets allowed (reset value)
    push_byte(VER_BASE2, 1'b1);                      // header cut at version
    push_byte(VER_BASE3, 1'b0); push_byte(8'd5, 1'b1);  // header cut in count
    add_bitmap(VER_BASE2, 16'd0, 0);                 // empty bitmap
    push_byte(VER_BASE2, 1'b0); push_byte(8'd11, 1'b0); push_byte(8'd0, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);  // partial last byte masked
    push_byte(VER_BASE3, 1'b0); push_byte(8'd7, 1'b0); push_byte(8'd0, 1'b0);
    push_byte(8'd242, 1'b0); push_byte(8'd255, 1'b0);  // all-fallback, then over 242
    push_byte(8'h55, 1'b1);                          // trailing byte
    push_byte(8'd2, 1'b0); push_byte(8'd0, 1'b0); push_byte(8'd0, 1'b1);  // malformed
    push_byte(VER_BASE2, 1'b0); push_byte(8'd1, 1'b0); push_byte(8'd8, 1'b0);
    push_byte(8'hAA, 1'b1);                          // count just over the limit
    push_byte(VER_BASE2, 1'b0); push_byte(8'd20, 1'b0); push_byte(8'd0, 1'b0);
    push_byte(8'h5A, 1'b1);                          // payload cut short
    wait_idle(8);

    // Directed, single set only
    set_allow(1'b0);
    push_byte(VER_BASE3, 1'b0); push_byte(8'd3, 1'b0); push_byte(8'd0, 1'b0);
    push_byte(8'h10, 1'b1);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
    push_byte(VER_BASE2, 1'b0); push_byte(8'd3, 1'b0); push_byte(8'd0, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_idle(8);

    // Random phases across register settings
    add_traffic(80);
    wait_idle(8);
    set_allow(1'b1);
    add_bitmap(VER_BASE2, 16'(MAX_RANKS), needed_bytes(1'b0, MAX_RANKS));
    add_traffic(80);
    wait_idle(8);
    set_allow(1'b0);
    add_traffic(50);
    wait_idle(8);
    set_allow(1'b1);
    no_idle = 1'b1;
    add_traffic(110);
    wait_idle(8);
    no_idle = 1'b0;
    add_bitmap(VER_BASE3, 16'(MAX_RANKS), needed_bytes(1'b1, MAX_RANKS));
    add_traffic(70);
    wait_idle(20);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sbd_pkg.sv
hdl/sbd_decode.sv
hdl/sbd_result_fifo.sv
hdl/signer_bitmap_base2_base3_decoder.sv
bench/signer_bitmap_base2_base3_decoder_tb.sv
